// ===== hw/rtl/bce_pkg.sv =====
// Package with the curve tables, health codes and register indexes of the charge estimator.
`default_nettype none
package bce_pkg;

   localparam logic [15:0] CURVE_TOP_MV    = 16'd4200;
   localparam logic [15:0] CURVE_BOTTOM_MV = 16'd3200;
   localparam logic [15:0] CURVE_STEP_MV   = 16'd100;
   localparam int unsigned CURVE_SEGMENTS  = 10;

   localparam logic [15:0] RESET_CRITICAL_MV = 16'd3300;
   localparam logic [15:0] RESET_LOW_MV      = 16'd3500;

   // Numerator scale: one percent is one hundredth of it.
   localparam logic [13:0] PCT_SCALE   = 14'd100;
   localparam logic [13:0] PCT_ROUND   = 14'd50;
   localparam logic [13:0] NUM_FULL    = 14'd10000;
   // x / 100 == (x * 5243) >> 19 holds exactly for every x below 43699.
   localparam logic [12:0] RECIP_MUL   = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;

   localparam logic [2:0] HEALTH_OK       = 3'd0;
   localparam logic [2:0] HEALTH_LOW      = 3'd1;
   localparam logic [2:0] HEALTH_CRITICAL = 3'd2;
   localparam logic [2:0] HEALTH_CHARGING = 3'd3;
   localparam logic [2:0] HEALTH_EXTERNAL = 3'd4;

   localparam logic CSR_CRITICAL_IDX = 1'b0;
   localparam logic CSR_LOW_IDX      = 1'b1;

   typedef logic [3:0] seg_type;

   // Percent at curve point k, counted down from the top point.
   function automatic logic [6:0] curve_pct(input seg_type k);
      logic [6:0] p;
      case (k)
         4'd0:    p = 7'd100;
         4'd1:    p = 7'd90;
         4'd2:    p = 7'd80;
         4'd3:    p = 7'd70;
         4'd4:    p = 7'd55;
         4'd5:    p = 7'd40;
         4'd6:    p = 7'd25;
         4'd7:    p = 7'd15;
         4'd8:    p = 7'd8;
         4'd9:    p = 7'd3;
         default: p = 7'd0;
      endcase
      return p;
   endfunction

   // Voltage of curve point k.
   function automatic logic [15:0] curve_mv(input seg_type k);
      logic [15:0] step_total;
      step_total = 16'(k) * CURVE_STEP_MV;
      return CURVE_TOP_MV - step_total;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bce_if.sv =====
// Sample and status channel interfaces of the charge estimator.
`default_nettype none
interface bce_req_if;
   logic        valid;
   logic        ready;
   logic        sample_valid;
   logic [15:0] cell_voltage_mv;
   logic        is_charging;
   logic        has_external_power;

   modport source (output valid, sample_valid, cell_voltage_mv, is_charging,
                   has_external_power, input ready);
   modport sink   (input valid, sample_valid, cell_voltage_mv, is_charging,
                   has_external_power, output ready);
endinterface

interface bce_rsp_if;
   logic        valid;
   logic        ready;
   logic        status_valid;
   logic [15:0] voltage_echo_mv;
   logic        charging_echo;
   logic        external_power_echo;
   logic [6:0]  charge_percent;
   logic [2:0]  health_class;

   modport source (output valid, status_valid, voltage_echo_mv, charging_echo,
                   external_power_echo, charge_percent, health_class, input ready);
   modport sink   (input valid, status_valid, voltage_echo_mv, charging_echo,
                   external_power_echo, charge_percent, health_class, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/battery_charge_estimator_core.sv =====
// Top level of the battery charge estimator: sample in, charge and health status out.
//
// Each word on req_ch is one battery sample; each word on rsp_ch is the status
// it produces, exactly one per sample and in order. The state of charge is a
// piecewise linear interpolation over an eleven point Li-ion curve from 3200 mV
// to 4200 mV, rounded half up and clamped. The health class ranks charging,
// external power, then the critical and low thresholds held in csr_ registers.
// A sample marked not valid yields a status word with every field zero.
//
// The block is a two register pipeline. The first register holds the segment
// interpolation numerator and the health class; the second holds the result
// after the divide by 100, done as a reciprocal multiply. A sample is held in
// the first stage, then in the result register, which offers it on rsp_ch;
// one sample can be taken every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word and the first
// stage fills; req_ch.ready drops only once both are full.
//
// Reset clears both pipeline stages and sets thresholds to 3300 mV and 3500 mV.
// Write thresholds only while no sample is in flight; the block does not check.
`default_nettype none
module battery_charge_estimator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   bce_req_if.sink          req_ch,
   bce_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // ---------------------------------------------------------------------
   // Threshold registers. Register index is address bit 2.
   // ---------------------------------------------------------------------
   logic [15:0] critical_mv_ff, critical_mv_in;
   logic [15:0] low_mv_ff, low_mv_in;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      critical_mv_in = critical_mv_ff;
      low_mv_in      = low_mv_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            bce_pkg::CSR_CRITICAL_IDX: critical_mv_in = csr_pwdata[15:0];
            bce_pkg::CSR_LOW_IDX:      low_mv_in      = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         bce_pkg::CSR_CRITICAL_IDX: csr_prdata = {16'd0, critical_mv_ff};
         bce_pkg::CSR_LOW_IDX:      csr_prdata = {16'd0, low_mv_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         critical_mv_ff <= bce_pkg::RESET_CRITICAL_MV;
         low_mv_ff      <= bce_pkg::RESET_LOW_MV;
      end else begin
         critical_mv_ff <= critical_mv_in;
         low_mv_ff      <= low_mv_in;
      end
   end

   // ---------------------------------------------------------------------
   // Handshake. Stage two is the result register; stage one moves into it
   // whenever it is empty or being drained this cycle.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s2_load;
   logic s1_take;

   assign s2_load      = s1_valid_ff && (!s2_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s2_load;
   assign s1_take      = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ch.ready) begin
         s1_valid_in = req_ch.valid;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage one logic: pick the curve segment, form the rounded numerator
   // 100*p0 - (hi - v)*(p0 - p1) + 50, and rank the health class.
   // ---------------------------------------------------------------------
   logic [15:0]      volt;
   bce_pkg::seg_type seg;
   logic [15:0]      hi_mv;
   logic [15:0]      gap_full;
   logic [6:0]       gap_mv;
   logic [6:0]       p0;
   logic [6:0]       p1;
   logic [3:0]       slope;
   logic [10:0]      drop;
   logic [13:0]      num_in;
   logic [2:0]       health_in;

   assign volt = req_ch.cell_voltage_mv;

   // The segment index is how many inner breakpoints lie above the voltage.
   always_comb begin
      seg = '0;
      for (int k = 1; k < bce_pkg::CURVE_SEGMENTS; k++) begin
         if (volt < bce_pkg::curve_mv(bce_pkg::seg_type'(k))) begin
            seg = bce_pkg::seg_type'(k);
         end
      end
   end

   assign hi_mv    = bce_pkg::curve_mv(seg);
   assign gap_full = hi_mv - volt;
   // Inside the curve the gap to the upper point is 1 to 100 mV.
   assign gap_mv   = gap_full[6:0];
   assign p0       = bce_pkg::curve_pct(seg);
   assign p1       = bce_pkg::curve_pct(seg + 4'd1);
   // No segment falls by more than 15 percent.
   assign slope    = 4'(p0 - p1);
   assign drop     = 11'(gap_mv) * 11'(slope);

   always_comb begin
      if (volt >= bce_pkg::CURVE_TOP_MV) begin
         num_in = bce_pkg::NUM_FULL;
      end else if (volt <= bce_pkg::CURVE_BOTTOM_MV) begin
         num_in = '0;
      end else begin
         num_in = 14'(p0) * bce_pkg::PCT_SCALE - 14'(drop) + bce_pkg::PCT_ROUND;
      end
   end

   always_comb begin
      if (req_ch.is_charging) begin
         health_in = bce_pkg::HEALTH_CHARGING;
      end else if (req_ch.has_external_power) begin
         health_in = bce_pkg::HEALTH_EXTERNAL;
      end else if (volt <= critical_mv_ff) begin
         health_in = bce_pkg::HEALTH_CRITICAL;
      end else if (volt <= low_mv_ff) begin
         health_in = bce_pkg::HEALTH_LOW;
      end else begin
         health_in = bce_pkg::HEALTH_OK;
      end
   end

   logic        s1_sample_ff;
   logic [15:0] s1_volt_ff;
   logic        s1_chg_ff;
   logic        s1_ext_ff;
   logic [13:0] s1_num_ff;
   logic [2:0]  s1_health_ff;

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_sample_ff <= req_ch.sample_valid;
         s1_volt_ff   <= volt;
         s1_chg_ff    <= req_ch.is_charging;
         s1_ext_ff    <= req_ch.has_external_power;
         s1_num_ff    <= num_in;
         s1_health_ff <= health_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage two logic: divide the numerator by 100 with a reciprocal
   // multiply, and zero the whole word for a sample that is not valid.
   // ---------------------------------------------------------------------
   logic [26:0] recip_prod;
   logic [6:0]  pct_in;

   assign recip_prod = 27'(s1_num_ff) * 27'(bce_pkg::RECIP_MUL);
   assign pct_in     = recip_prod[bce_pkg::RECIP_SHIFT +: 7];

   logic        s2_sample_ff;
   logic [15:0] s2_volt_ff;
   logic        s2_chg_ff;
   logic        s2_ext_ff;
   logic [6:0]  s2_pct_ff;
   logic [2:0]  s2_health_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_sample_ff <= s1_sample_ff;
         if (s1_sample_ff) begin
            s2_volt_ff   <= s1_volt_ff;
            s2_chg_ff    <= s1_chg_ff;
            s2_ext_ff    <= s1_ext_ff;
            s2_pct_ff    <= pct_in;
            s2_health_ff <= s1_health_ff;
         end else begin
            s2_volt_ff   <= '0;
            s2_chg_ff    <= 1'b0;
            s2_ext_ff    <= 1'b0;
            s2_pct_ff    <= '0;
            s2_health_ff <= bce_pkg::HEALTH_OK;
         end
      end
   end

   assign rsp_ch.valid               = s2_valid_ff;
   assign rsp_ch.status_valid        = s2_sample_ff;
   assign rsp_ch.voltage_echo_mv     = s2_volt_ff;
   assign rsp_ch.charging_echo       = s2_chg_ff;
   assign rsp_ch.external_power_echo = s2_ext_ff;
   assign rsp_ch.charge_percent      = s2_pct_ff;
   assign rsp_ch.health_class        = s2_health_ff;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the battery charge estimator core.
`default_nettype none
module tb_top;

   // The run ends as failed once the quiet count, of cycles with no word moving on
   // either channel and no register access in progress, goes past this limit.
   localparam int unsigned QUIET_LIMIT   = 4000;
   // Random words per traffic phase, and number of phases.
   localparam int unsigned PHASE_WORDS   = 150;
   localparam int unsigned PHASE_COUNT   = 8;
   // The status word trails its sample through both pipeline registers, so these
   // spare cycles after the last status word cover anything still inside the pipeline.
   localparam int unsigned SETTLE_CYCLES = 4;

   // Discharge curve used by the checker: 100 mV steps from the top point down.
   localparam int unsigned TOP_MV    = 4200;
   localparam int unsigned BOTTOM_MV = 3200;
   localparam int unsigned STEP_MV   = 100;

   typedef struct packed {
      logic        sample_valid;
      logic [15:0] cell_mv;
      logic        charging;
      logic        ext_power;
   } sample_type;

   typedef struct packed {
      logic        status_valid;
      logic [15:0] voltage_mv;
      logic        charging;
      logic        ext_power;
      logic [6:0]  charge_pct;
      logic [2:0]  health;
   } status_type;

   // One sample to send; when typed is set, want is the status written down
   // by hand and the checker's own estimate is not used for it.
   typedef struct packed {
      sample_type s;
      logic       typed;
      status_type want;
   } feed_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bce_req_if req_ch ();
   bce_rsp_if rsp_ch ();

   battery_charge_estimator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copies of the two threshold registers. They only change while the
   // pipeline is empty, so the estimate made at acceptance time is final.
   logic [15:0] thr_critical_mv;
   logic [15:0] thr_low_mv;

   // Status words still owed by the block, oldest first.
   status_type  owed_status_q[$];
   feed_type    directed_q[$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned fail_count;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Percent at curve point k, counted down from the top point.
   function automatic int unsigned knee_pct(input int unsigned k);
      case (k)
         0: return 100;
         1: return 90;
         2: return 80;
         3: return 70;
         4: return 55;
         5: return 40;
         6: return 25;
         7: return 15;
         8: return 8;
         9: return 3;
         default: return 0;
      endcase
   endfunction

   // State of charge: clamp outside the curve, otherwise interpolate inside
   // the 100 mV segment that holds the voltage, scaled by 100 and rounded
   // half up by adding 50 before the divide.
   function automatic logic [6:0] charge_pct_of(input logic [15:0] mv);
      int unsigned seg;
      int unsigned hi;
      int unsigned p0;
      int unsigned p1;
      int unsigned num;
      if (mv >= TOP_MV) return 7'd100;
      if (mv <= BOTTOM_MV) return 7'd0;
      seg = (TOP_MV - 1 - mv) / STEP_MV;
      hi  = TOP_MV - seg * STEP_MV;
      p0  = knee_pct(seg);
      p1  = knee_pct(seg + 1);
      num = 100 * p0 - (hi - mv) * (p0 - p1);
      return 7'((num + 50) / 100);
   endfunction

   // Full status word for one sample under the current thresholds. The health
   // class is a priority chain: charging wins over external power, and the
   // critical test is made before the low test.
   function automatic status_type estimate_status(input sample_type s);
      status_type r;
      r = '0;
      if (!s.sample_valid) return r;
      r.status_valid = 1'b1;
      r.voltage_mv   = s.cell_mv;
      r.charging     = s.charging;
      r.ext_power    = s.ext_power;
      r.charge_pct   = charge_pct_of(s.cell_mv);
      if (s.charging)                        r.health = bce_pkg::HEALTH_CHARGING;
      else if (s.ext_power)                  r.health = bce_pkg::HEALTH_EXTERNAL;
      else if (s.cell_mv <= thr_critical_mv) r.health = bce_pkg::HEALTH_CRITICAL;
      else if (s.cell_mv <= thr_low_mv)      r.health = bce_pkg::HEALTH_LOW;
      else                                   r.health = bce_pkg::HEALTH_OK;
      return r;
   endfunction

   // Adds a row to the directed table. With typed set, pct and health are the
   // hand-written answer; the echo fields simply copy the sample, and a sample
   // marked not valid expects an all-zero word.
   task automatic add_row(input logic sv, input logic [15:0] mv, input logic chg,
                          input logic ext, input logic typed, input logic [6:0] pct,
                          input logic [2:0] health);
      feed_type f;
      f.s.sample_valid = sv;
      f.s.cell_mv      = mv;
      f.s.charging     = chg;
      f.s.ext_power    = ext;
      f.typed          = typed;
      f.want           = '0;
      if (typed && sv) begin
         f.want.status_valid = 1'b1;
         f.want.voltage_mv   = mv;
         f.want.charging     = chg;
         f.want.ext_power    = ext;
         f.want.charge_pct   = pct;
         f.want.health       = health;
      end
      directed_q.push_back(f);
   endtask

   // Random sample. Most voltages fall on or near the curve, a share sits
   // right at the thresholds and the breakpoints, and the rest spans all
   // sixteen bits so every bit of the field is exercised.
   function automatic sample_type random_sample();
      sample_type  s;
      int unsigned pick;
      s.sample_valid = ($urandom_range(99, 0) < 88);
      s.charging     = ($urandom_range(99, 0) < 15);
      s.ext_power    = ($urandom_range(99, 0) < 15);
      pick = $urandom_range(99, 0);
      if (pick < 55)
         s.cell_mv = 16'($urandom_range(4250, 3150));
      else if (pick < 70)
         s.cell_mv = (pick[0] ? thr_low_mv : thr_critical_mv)
                     + 16'($urandom_range(6, 0)) - 16'd3;
      else if (pick < 85)
         s.cell_mv = 16'(TOP_MV - STEP_MV * $urandom_range(10, 0))
                     + 16'($urandom_range(2, 0)) - 16'd1;
      else
         s.cell_mv = 16'($urandom);
      return s;
   endfunction

   // Presents one sample word, starting and ending on a falling edge. Idle
   // cycles before it are drawn from send_idle_pct. The owed status word is
   // queued at the edge where the sample is taken.
   task automatic send_word(input feed_type f);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid              <= 1'b1;
      req_ch.sample_valid       <= f.s.sample_valid;
      req_ch.cell_voltage_mv    <= f.s.cell_mv;
      req_ch.is_charging        <= f.s.charging;
      req_ch.has_external_power <= f.s.ext_power;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (f.typed) owed_status_q.push_back(f.want);
      else         owed_status_q.push_back(estimate_status(f.s));
      @(negedge clock);
   endtask

   // One register access: setup cycle, then access cycle. A write updates the
   // shadow copy at the edge that commits it; a read is checked against it.
   task automatic csr_access(input logic idx, input logic wr, input logic [15:0] value);
      logic [15:0] shadow;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      shadow = (idx == bce_pkg::CSR_LOW_IDX) ? thr_low_mv : thr_critical_mv;
      if (wr) begin
         if (idx == bce_pkg::CSR_LOW_IDX) thr_low_mv = value;
         else                             thr_critical_mv = value;
      end else if (csr_prdata[15:0] !== shadow) begin
         $error("csr_prdata[%0d]: expected %0d, got %0d", idx, shadow, csr_prdata[15:0]);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Waits for every owed status word, then lets the pipeline settle.
   task automatic wait_drained();
      while (owed_status_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // The receiver decides on each falling edge whether to stall the next edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // Every status word taken is compared with the oldest owed one.
   always @(posedge clock) begin : status_check
      status_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (owed_status_q.size() == 0) begin
            $error("status word arrived with no sample outstanding");
            fail_count++;
         end else begin
            want = owed_status_q.pop_front();
            check_field("status_valid", want.status_valid, rsp_ch.status_valid);
            check_field("voltage_echo_mv", want.voltage_mv, rsp_ch.voltage_echo_mv);
            check_field("charging_echo", want.charging, rsp_ch.charging_echo);
            check_field("external_power_echo", want.ext_power, rsp_ch.external_power_echo);
            check_field("charge_percent", want.charge_pct, rsp_ch.charge_percent);
            check_field("health_class", want.health, rsp_ch.health_class);
         end
      end
   end

   // Watchdog: a hung handshake ends the run instead of spinning forever.
   always @(posedge clock) begin
      if (reset || csr_psel || (req_ch.valid && req_ch.ready)
          || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      feed_type    f;
      logic [15:0] crit;
      logic [15:0] low;
      // Every input of the block holds a known value from time zero.
      reset                     = 1'b1;
      csr_psel                  = 1'b0;
      csr_penable               = 1'b0;
      csr_pwrite                = 1'b0;
      csr_paddr                 = '0;
      csr_pwdata                = '0;
      req_ch.valid              = 1'b0;
      req_ch.sample_valid       = 1'b0;
      req_ch.cell_voltage_mv    = '0;
      req_ch.is_charging        = 1'b0;
      req_ch.has_external_power = 1'b0;
      rsp_ch.ready              = 1'b0;
      send_idle_pct             = 0;
      recv_stall_pct            = 0;
      fail_count                = 0;
      quiet_cycles              = 0;
      thr_critical_mv           = 16'd3300;
      thr_low_mv                = 16'd3500;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Both registers must come out of reset at their documented values.
      csr_access(bce_pkg::CSR_CRITICAL_IDX, 1'b0, 16'h0000);
      csr_access(bce_pkg::CSR_LOW_IDX, 1'b0, 16'h0000);

      // Directed table under the reset thresholds (critical 3300, low 3500).
      // Invalid samples with every other bit set or clear must still give all zeros.
      add_row(1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 7'd0, bce_pkg::HEALTH_OK);
      add_row(1'b0, 16'h0000, 1'b0, 1'b0, 1'b1, 7'd0, bce_pkg::HEALTH_OK);
      // Field extremes and the clamps at both ends of the curve.
      add_row(1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, 7'd0, bce_pkg::HEALTH_CRITICAL);
      add_row(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 7'd100, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd4200, 1'b0, 1'b0, 1'b1, 7'd100, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3200, 1'b0, 1'b0, 1'b1, 7'd0, bce_pkg::HEALTH_CRITICAL);
      // Exact breakpoints, including voltages sitting on each threshold.
      add_row(1'b1, 16'd4100, 1'b0, 1'b0, 1'b1, 7'd90, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3900, 1'b0, 1'b0, 1'b1, 7'd70, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3700, 1'b0, 1'b0, 1'b1, 7'd40, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3500, 1'b0, 1'b0, 1'b1, 7'd15, bce_pkg::HEALTH_LOW);
      add_row(1'b1, 16'd3400, 1'b0, 1'b0, 1'b1, 7'd8, bce_pkg::HEALTH_LOW);
      add_row(1'b1, 16'd3300, 1'b0, 1'b0, 1'b1, 7'd3, bce_pkg::HEALTH_CRITICAL);
      // One step inside the ends and past each threshold, a midpoint that
      // rounds up, and a low value that rounds down to zero.
      add_row(1'b1, 16'd4199, 1'b0, 1'b0, 1'b0, 7'd0, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3201, 1'b0, 1'b0, 1'b0, 7'd0, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3301, 1'b0, 1'b0, 1'b0, 7'd0, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3501, 1'b0, 1'b0, 1'b0, 7'd0, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3650, 1'b0, 1'b0, 1'b0, 7'd0, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd3205, 1'b0, 1'b0, 1'b0, 7'd0, bce_pkg::HEALTH_OK);
      add_row(1'b1, 16'd4150, 1'b0, 1'b0, 1'b0, 7'd0, bce_pkg::HEALTH_OK);
      // Health priority: charging over external power over the thresholds.
      add_row(1'b1, 16'd3850, 1'b1, 1'b0, 1'b1, 7'd63, bce_pkg::HEALTH_CHARGING);
      add_row(1'b1, 16'd3850, 1'b0, 1'b1, 1'b1, 7'd63, bce_pkg::HEALTH_EXTERNAL);
      add_row(1'b1, 16'd3250, 1'b1, 1'b1, 1'b1, 7'd2, bce_pkg::HEALTH_CHARGING);

      foreach (directed_q[i]) send_word(directed_q[i]);
      req_ch.valid <= 1'b0;
      wait_drained();

      // Random phases. Each one loads new thresholds while the block is idle,
      // covering the extremes and a low threshold below the critical one, then
      // runs under one of four idling patterns.
      for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin crit = 16'd0;     low = 16'hFFFF; end
            1: begin crit = 16'hFFFF;  low = 16'd0;    end
            2: begin crit = 16'd3600;  low = 16'd3400; end
            3: begin crit = 16'd3300;  low = 16'd3500; end
            default: begin
               crit = 16'($urandom_range(3700, 3150));
               low  = 16'($urandom_range(4250, 3250));
            end
         endcase
         csr_access(bce_pkg::CSR_CRITICAL_IDX, 1'b1, crit);
         csr_access(bce_pkg::CSR_LOW_IDX, 1'b1, low);
         csr_access(bce_pkg::CSR_CRITICAL_IDX, 1'b0, 16'h0000);
         csr_access(bce_pkg::CSR_LOW_IDX, 1'b0, 16'h0000);

         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase

         for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
            f.s     = random_sample();
            f.typed = 1'b0;
            f.want  = '0;
            send_word(f);
         end
         req_ch.valid <= 1'b0;
         recv_stall_pct = 0;
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/bce_pkg.sv
hw/rtl/bce_if.sv
hw/rtl/battery_charge_estimator_core.sv
test/tb_top.sv
